// ----- rtl/core/bbs_pkg.sv -----
package bbs_pkg;

  localparam int PRICE_W    = 24;
  localparam int BAND_W     = 28;
  localparam int SQ_W       = 2 * PRICE_W;
  localparam int EXT_W      = BAND_W + 2;
  localparam int WL_W       = 7;
  localparam int GAIN_W     = 12;
  localparam int GAIN_FRAC  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [WL_W-1:0]   WL_RESET   = 7'd20;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd512;

  localparam logic signed [EXT_W-1:0] BAND_TOP    = EXT_W'((64'sd1 <<< (BAND_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] BAND_BOTTOM = EXT_W'(-(64'sd1 <<< (BAND_W - 1)));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_GAIN   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic            ge;
    logic [SQ_W-1:0] diff;
  } step_res_t;

endpackage

// ----- rtl/core/bbs_if.sv -----
interface bbs_in_if import bbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] close_price;

  modport source (output valid, output close_price, input ready);
  modport sink (input valid, input close_price, output ready);
endinterface

interface bbs_out_if import bbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PRICE_W-1:0]       mid_band;
  logic signed [BAND_W-1:0] upper_band;
  logic signed [BAND_W-1:0] lower_band;
  logic                     mid_valid;
  logic                     band_valid;

  modport source (output valid, output mid_band, output upper_band, output lower_band,
                  output mid_valid, output band_valid, input ready);
  modport sink (input valid, input mid_band, input upper_band, input lower_band,
                input mid_valid, input band_valid, output ready);
endinterface

// ----- rtl/core/bollinger_band_stream.sv -----
// Bollinger band stream.
// in_i carries one close price per transfer; out_o carries one result per
// accepted price. Each result reports the average and bands computed for the
// previous price (all zero after reset or after a window_length write).
// The result of a price is loaded into the output register on the cycle the
// price is taken, so it shows in the cycle after the transfer.
// Work per price: ring read, accumulate, average division (30 steps at the
// default size), squared deviation and its accumulation; once the bands are
// valid, a 54-step division, 24-step square root and gain multiply; then the
// band update. Division and root steps use the single compare-subtract unit.
// Both ring memories start empty; a fill count stands in for their reset
// contents, so there is no clearing pass.
// in_i.ready drops while a price is in work, and also while a result waits
// in the output register that out_o has not taken.
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must make them only while the block is idle, which the block itself
// does not enforce. A window_length write restarts the stream.
module bollinger_band_stream import bbs_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bbs_in_if.sink                in_i,
  bbs_out_if.source             out_o
);

  localparam int PW    = $clog2(WINDOW_MAX);
  localparam int NW    = $clog2(WINDOW_MAX + 1);
  localparam int SW    = $clog2(2 * WINDOW_MAX + 1);
  localparam int TOT_W = PRICE_W + PW;
  localparam int SQT_W = SQ_W + PW;
  localparam int CW    = $clog2(SQT_W);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_READ  = 10'b0000000010,
    ST_ACC   = 10'b0000000100,
    ST_DIVM  = 10'b0000001000,
    ST_MUL   = 10'b0000010000,
    ST_SQACC = 10'b0000100000,
    ST_DIVS  = 10'b0001000000,
    ST_SQRT  = 10'b0010000000,
    ST_GAIN  = 10'b0100000000,
    ST_BAND  = 10'b1000000000
  } state_e;

  state_e                   st_q;
  logic [WL_W-1:0]          wl_q;
  logic [GAIN_W-1:0]        gain_q;
  logic [TOT_W-1:0]         total_q;
  logic [SQT_W-1:0]         sqtot_q;
  logic [SW-1:0]            seen_q;
  logic [PW-1:0]            pos_q;
  logic [PRICE_W-1:0]       held_mid_q;
  logic signed [BAND_W-1:0] held_up_q, held_lo_q;
  logic                     held_mv_q, held_bv_q;
  logic                     out_v_q;
  logic [PRICE_W-1:0]       out_mid_q;
  logic signed [BAND_W-1:0] out_up_q, out_lo_q;
  logic                     out_mv_q, out_bv_q;
  logic [PRICE_W-1:0]       price_q, mid_q;
  logic [SQ_W-1:0]          sq_q;
  logic [SQT_W-1:0]         quo_q;
  logic [SQ_W-1:0]          rem_q, x_q, r_q, bit_q;
  logic [CW-1:0]            cnt_q;
  logic [BAND_W-1:0]        g_q;

  logic [NW-1:0]            n;
  logic                     mid_ok, band_ok, written, accept;
  logic [PRICE_W-1:0]       c_rdata, c_old, d_abs, quo_mid;
  logic [SQ_W-1:0]          s_rdata, s_old, trial, op_a, op_b;
  logic [TOT_W-1:0]         total_d;
  logic [SQT_W-1:0]         sqtot_d;
  logic                     c_we, s_we, rd_en;
  step_res_t                step;
  logic [GAIN_W+PRICE_W-1:0] prod;
  logic signed [EXT_W-1:0]  up_ext, lo_ext;

  always_comb begin
    if (wl_q < WL_W'(2)) begin
      n = NW'(2);
    end else if (int'(wl_q) > WINDOW_MAX) begin
      n = NW'(WINDOW_MAX);
    end else begin
      n = NW'(wl_q);
    end
  end

  assign mid_ok  = ({1'b0, seen_q} + (SW+1)'(1)) >= (SW+1)'(n);
  assign band_ok = {1'b0, seen_q} >= ((SW+1)'(n) << 1);
  assign written = SW'(pos_q) < seen_q;
  assign accept  = in_i.valid && in_i.ready;

  assign c_old   = written ? c_rdata : '0;
  assign s_old   = written ? s_rdata : '0;
  assign total_d = total_q - TOT_W'(c_old) + TOT_W'(price_q);
  assign sqtot_d = sqtot_q - SQT_W'(s_old) + SQT_W'(sq_q);
  assign quo_mid = quo_q[PRICE_W-1:0];
  assign d_abs   = (price_q >= quo_mid) ? price_q - quo_mid : quo_mid - price_q;
  assign prod    = gain_q * r_q[PRICE_W-1:0];
  assign up_ext  = $signed(EXT_W'(mid_q)) + $signed(EXT_W'(g_q));
  assign lo_ext  = $signed(EXT_W'(mid_q)) - $signed(EXT_W'(g_q));

  assign trial = {rem_q[SQ_W-2:0], quo_q[SQT_W-1]};
  assign op_a  = (st_q == ST_SQRT) ? x_q : trial;
  assign op_b  = (st_q == ST_SQRT) ? (r_q | bit_q) : SQ_W'(n);

  assign rd_en = (st_q == ST_READ);
  assign c_we  = (st_q == ST_ACC);
  assign s_we  = (st_q == ST_SQACC);

  bbs_step u_step (
    .a_i   (op_a),
    .b_i   (op_b),
    .res_o (step)
  );

  bbs_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_MAX)) u_close_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (pos_q),
    .wdata_i (price_q),
    .re_i    (rd_en),
    .raddr_i (pos_q),
    .rdata_o (c_rdata)
  );

  bbs_ram #(.WIDTH(SQ_W), .DEPTH(WINDOW_MAX)) u_square_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (pos_q),
    .wdata_i (sq_q),
    .re_i    (rd_en),
    .raddr_i (pos_q),
    .rdata_o (s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      wl_q       <= WL_RESET;
      gain_q     <= GAIN_RESET;
      total_q    <= '0;
      sqtot_q    <= '0;
      seen_q     <= '0;
      pos_q      <= '0;
      held_mid_q <= '0;
      held_up_q  <= '0;
      held_lo_q  <= '0;
      held_mv_q  <= 1'b0;
      held_bv_q  <= 1'b0;
      out_v_q    <= 1'b0;
      out_mid_q  <= '0;
      out_up_q   <= '0;
      out_lo_q   <= '0;
      out_mv_q   <= 1'b0;
      out_bv_q   <= 1'b0;
      price_q    <= '0;
      mid_q      <= '0;
      sq_q       <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      x_q        <= '0;
      r_q        <= '0;
      bit_q      <= '0;
      cnt_q      <= '0;
      g_q        <= '0;
    end else begin
      if (accept) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            price_q   <= in_i.close_price;
            out_mid_q <= held_mid_q;
            out_up_q  <= held_up_q;
            out_lo_q  <= held_lo_q;
            out_mv_q  <= held_mv_q;
            out_bv_q  <= held_bv_q;
            st_q      <= ST_READ;
          end
        end
        ST_READ: begin
          st_q <= ST_ACC;
        end
        ST_ACC: begin
          total_q <= total_d;
          quo_q   <= {total_d, {(SQT_W - TOT_W){1'b0}}};
          rem_q   <= '0;
          cnt_q   <= CW'(TOT_W - 1);
          st_q    <= ST_DIVM;
        end
        ST_DIVM, ST_DIVS: begin
          rem_q <= step.ge ? step.diff : trial;
          quo_q <= {quo_q[SQT_W-2:0], step.ge};
          if (cnt_q == '0) begin
            if (st_q == ST_DIVM) begin
              st_q <= ST_MUL;
            end else begin
              x_q   <= SQ_W'({quo_q[SQT_W-2:0], step.ge});
              r_q   <= '0;
              bit_q <= SQ_W'(1) << (SQ_W - 2);
              cnt_q <= CW'(SQ_W / 2 - 1);
              st_q  <= ST_SQRT;
            end
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_MUL: begin
          mid_q <= mid_ok ? quo_mid : '0;
          sq_q  <= mid_ok ? d_abs * d_abs : '0;
          st_q  <= ST_SQACC;
        end
        ST_SQACC: begin
          sqtot_q <= sqtot_d;
          quo_q   <= sqtot_d;
          rem_q   <= '0;
          cnt_q   <= CW'(SQT_W - 1);
          st_q    <= band_ok ? ST_DIVS : ST_BAND;
        end
        ST_SQRT: begin
          if (step.ge) begin
            x_q <= step.diff;
            r_q <= (r_q >> 1) | bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            st_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          g_q  <= BAND_W'(prod >> GAIN_FRAC);
          st_q <= ST_BAND;
        end
        ST_BAND: begin
          held_mid_q <= mid_q;
          held_mv_q  <= mid_ok;
          held_bv_q  <= band_ok;
          if (band_ok) begin
            held_up_q <= (up_ext > BAND_TOP) ? BAND_W'(BAND_TOP) : BAND_W'(up_ext);
            held_lo_q <= (lo_ext < BAND_BOTTOM) ? BAND_W'(BAND_BOTTOM) : BAND_W'(lo_ext);
          end else begin
            held_up_q <= '0;
            held_lo_q <= '0;
          end
          if (int'(seen_q) < 2 * WINDOW_MAX) begin
            seen_q <= seen_q + SW'(1);
          end
          if ((NW+1)'(pos_q) + (NW+1)'(1) >= (NW+1)'(n)) begin
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + PW'(1);
          end
          st_q <= ST_IDLE;
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WINDOW: begin
            wl_q       <= cfg_data_i[WL_W-1:0];
            total_q    <= '0;
            sqtot_q    <= '0;
            seen_q     <= '0;
            pos_q      <= '0;
            held_mid_q <= '0;
            held_up_q  <= '0;
            held_lo_q  <= '0;
            held_mv_q  <= 1'b0;
            held_bv_q  <= 1'b0;
          end
          CFG_GAIN: begin
            gain_q <= cfg_data_i[GAIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign in_i.ready       = (st_q == ST_IDLE) && (!out_v_q || out_o.ready);
  assign out_o.valid      = out_v_q;
  assign out_o.mid_band   = out_mid_q;
  assign out_o.upper_band = out_up_q;
  assign out_o.lower_band = out_lo_q;
  assign out_o.mid_valid  = out_mv_q;
  assign out_o.band_valid = out_bv_q;

endmodule

// ----- rtl/core/bbs_ram.sv -----
module bbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/bbs_step.sv -----
module bbs_step import bbs_pkg::*; (
  input  logic [SQ_W-1:0] a_i,
  input  logic [SQ_W-1:0] b_i,
  output step_res_t       res_o
);

  logic [SQ_W:0] sub;

  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~sub[SQ_W];
  assign res_o.diff = sub[SQ_W-1:0];

endmodule

// ----- rtl/core/bbs_chk.sv -----
module bbs_chk import bbs_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [PRICE_W-1:0]       mid_band_i,
  input logic signed [BAND_W-1:0] upper_band_i,
  input logic signed [BAND_W-1:0] lower_band_i,
  input logic                     mid_valid_i,
  input logic                     band_valid_i
);

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready straight after a transfer");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after an input transfer");

  a_band_needs_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && band_valid_i |-> mid_valid_i)
    else $error("bands valid without a valid average");

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mid_valid_i || mid_band_i == '0) &&
                    (band_valid_i || (upper_band_i == '0 && lower_band_i == '0)))
    else $error("invalid fields not zero");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mid_band_i) &&
                                    $stable(upper_band_i))
    else $error("stalled result changed");

endmodule

bind bollinger_band_stream bbs_chk u_bbs_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .mid_band_i   (out_o.mid_band),
  .upper_band_i (out_o.upper_band),
  .lower_band_i (out_o.lower_band),
  .mid_valid_i  (out_o.mid_valid),
  .band_valid_i (out_o.band_valid)
);

// ----- verif/bollinger_band_stream_tb.sv -----
module bollinger_band_stream_tb;
  import bbs_pkg::*;

  localparam int                   WIN_MAX    = 64;
  localparam int                   SETTLE_CYC = 250;
  localparam int                   STALL_CAP  = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  typedef struct packed {
    logic [PRICE_W-1:0]       mid;
    logic signed [BAND_W-1:0] upper;
    logic signed [BAND_W-1:0] lower;
    logic                     mid_ok;
    logic                     band_ok;
  } band_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bbs_in_if  price_if ();
  bbs_out_if band_if ();

  bollinger_band_stream u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (price_if.sink),
    .out_o      (band_if.source)
  );

  // predictor state
  logic [WL_W-1:0]   model_wl;
  logic [GAIN_W-1:0] model_gain;
  logic [PRICE_W-1:0] close_hist [WIN_MAX];
  logic [SQ_W-1:0]    resid_hist [WIN_MAX];
  longint unsigned    close_sum;
  longint unsigned    resid_sum;
  int unsigned        seen_cnt;
  int unsigned        slot;
  band_result_t       held_res;

  band_result_t expected_bands[$];
  int           fail_cnt;
  int           idle_cnt;
  int           hold_len;
  bit           quiet;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic void clear_stream();
    for (int i = 0; i < WIN_MAX; i++) begin
      close_hist[i] = '0;
      resid_hist[i] = '0;
    end
    close_sum = 0;
    resid_sum = 0;
    seen_cnt  = 0;
    slot      = 0;
    held_res  = '0;
  endfunction

  function automatic band_result_t predict_bands(logic [PRICE_W-1:0] c);
    int unsigned     n;
    longint unsigned avg, d, sq, sigma, g;
    longint          up, lo;
    band_result_t    res, nxt;
    n = model_wl < 2 ? 2 : (model_wl > WIN_MAX ? WIN_MAX : model_wl);
    res = held_res;
    if (!res.band_ok) begin
      res.upper = '0;
      res.lower = '0;
    end
    if (slot >= n) slot = 0;
    close_sum = close_sum - close_hist[slot] + c;
    close_hist[slot] = c;
    avg = 0;
    sq  = 0;
    nxt = '0;
    if (seen_cnt + 1 >= n) begin
      avg = close_sum / n;
      d   = (c >= avg) ? c - avg : avg - c;
      sq  = d * d;
      nxt.mid_ok = 1'b1;
      nxt.mid    = avg[PRICE_W-1:0];
    end
    resid_sum = resid_sum - resid_hist[slot] + sq;
    resid_hist[slot] = sq[SQ_W-1:0];
    if (seen_cnt >= 2 * n) begin
      sigma = floor_root(resid_sum / n);
      g  = (longint'(model_gain) * sigma) >> GAIN_FRAC;
      up = longint'(avg) + longint'(g);
      lo = longint'(avg) - longint'(g);
      if (up > 134217727) up = 134217727;
      if (lo < -134217728) lo = -134217728;
      nxt.band_ok = 1'b1;
      nxt.upper   = up[BAND_W-1:0];
      nxt.lower   = lo[BAND_W-1:0];
    end
    held_res = nxt;
    slot = slot + 1;
    if (slot >= n) slot = 0;
    if (seen_cnt < 2 * WIN_MAX) seen_cnt++;
    return res;
  endfunction

  task automatic send_price(logic [PRICE_W-1:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      price_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    price_if.valid       <= 1'b1;
    price_if.close_price <= c;
    do @(posedge clk_i); while (!price_if.ready);
    expected_bands = {expected_bands, predict_bands(c)};
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    price_if.valid <= 1'b0;
    while (expected_bands.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_and_settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW) begin
      model_wl = data[WL_W-1:0];
      clear_stream();
    end else if (idx == CFG_GAIN) begin
      model_gain = data[GAIN_W-1:0];
    end
  endtask

  function automatic logic [PRICE_W-1:0] random_price();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return PRICE_W'($urandom);
    if (r < 8) return PRICE_W'(24'h800000 + $urandom_range(0, 4000) - 2000);
    return (r == 8) ? '0 : '1;
  endfunction

  task automatic test_directed_extremes();
    write_reg(CFG_WINDOW, 12'd2);
    write_reg(CFG_GAIN, 12'd4095);
    for (int i = 0; i < 8; i++) send_price(i[0] ? '1 : '0);
    write_reg(CFG_GAIN, 12'd0);
    for (int i = 0; i < 3; i++) send_price(24'h5A5A5A);
    write_reg(CFG_SPARE, 12'hFFF);
    write_reg(CFG_WINDOW, 12'hF80);
    for (int i = 0; i < 5; i++) send_price(PRICE_W'(24'hA5A5A5 ^ i));
    write_reg(CFG_WINDOW, 12'd127);
    for (int i = 0; i < 4; i++) send_price(random_price());
    write_reg(CFG_WINDOW, 12'd1);
    write_reg(CFG_GAIN, 12'd512);
    for (int i = 0; i < 5; i++) send_price(i[0] ? 24'h000001 : 24'hFFFFFE);
  endtask

  task automatic test_full_window();
    write_reg(CFG_WINDOW, 12'd64);
    write_reg(CFG_GAIN, GAIN_W'($urandom));
    for (int i = 0; i < 140; i++) send_price(random_price());
  endtask

  task automatic test_random_windows();
    int total, len;
    total = 0;
    while (total < 320) begin
      write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(0, 12) == 0 ?
                $urandom : $urandom_range(2, 12)));
      quiet = ($urandom_range(0, 3) == 0);
      len = $urandom_range(10, 40);
      for (int i = 0; i < len; i++) send_price(random_price());
      write_reg(CFG_GAIN, CFG_DATA_W'($urandom));
      for (int i = 0; i < len; i++) send_price(random_price());
      total += 2 * len;
      quiet = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WINDOW, 12'd3);
    hold_len = 400;
    for (int i = 0; i < 12; i++) send_price(random_price());
    drain_and_settle();
    for (int i = 0; i < 6; i++) send_price(random_price());
  endtask

  // sink side: random stalls, or a long hold-off on request
  initial begin
    int stall;
    band_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_len > 0) begin
        band_if.ready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
        hold_len = 0;
      end else if (stall > 0) begin
        band_if.ready <= 1'b0;
        stall--;
      end else begin
        band_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    band_result_t exp_r;
    if (rst_ni && band_if.valid && band_if.ready) begin
      if (expected_bands.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        exp_r = expected_bands.pop_front();
        if (band_if.mid_band !== exp_r.mid) begin
          $error("mid_band: expected %0d, got %0d", exp_r.mid, band_if.mid_band);
          fail_cnt++;
        end
        if (band_if.upper_band !== exp_r.upper) begin
          $error("upper_band: expected %0d, got %0d", exp_r.upper, band_if.upper_band);
          fail_cnt++;
        end
        if (band_if.lower_band !== exp_r.lower) begin
          $error("lower_band: expected %0d, got %0d", exp_r.lower, band_if.lower_band);
          fail_cnt++;
        end
        if (band_if.mid_valid !== exp_r.mid_ok) begin
          $error("mid_valid: expected %0b, got %0b", exp_r.mid_ok, band_if.mid_valid);
          fail_cnt++;
        end
        if (band_if.band_valid !== exp_r.band_ok) begin
          $error("band_valid: expected %0b, got %0b", exp_r.band_ok, band_if.band_valid);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((price_if.valid && price_if.ready) || (band_if.valid && band_if.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    fail_cnt             = 0;
    idle_cnt             = 0;
    hold_len             = 0;
    quiet                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_WINDOW;
    cfg_data_i           = '0;
    price_if.valid       = 1'b0;
    price_if.close_price = '0;
    model_wl             = WL_RESET;
    model_gain           = GAIN_RESET;
    clear_stream();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int i = 0; i < 3; i++) send_price(random_price());
    test_directed_extremes();
    test_full_window();
    test_random_windows();
    test_backpressure();
    drain_and_settle();
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
